FILE: rtl/nsv_pkg.sv
// nsv_pkg: shared types, codes and constants of the nmea sentence validator
// holds the transaction structs, status and type codes, the hex and type lookups
// no dependencies
package nsv_pkg;

    // sentence byte transaction
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } nsv_in_t;

    // result transaction
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] sentence_type;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
        logic [7:0] sentence_length;
    } nsv_out_t;

    // status codes, first failing check wins
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_LENGTH = 3'd1;
    localparam logic [2:0] STATUS_BAD_START  = 3'd2;
    localparam logic [2:0] STATUS_NO_STAR    = 3'd3;
    localparam logic [2:0] STATUS_MISMATCH   = 3'd4;

    // sentence type codes
    localparam logic [3:0] TYPE_UNKNOWN = 4'd0;
    localparam logic [3:0] TYPE_AIS     = 4'd12;
    localparam int         NUM_TYPES    = 11;

    // talker-independent sentence identifiers, code is position plus one
    localparam logic [23:0] TYPE_TABLE [NUM_TYPES] = '{
        {8'h57, 8'h4D, 8'h56},  // WMV
        {8'h4D, 8'h44, 8'h41},  // MDA
        {8'h4D, 8'h54, 8'h41},  // MTA
        {8'h52, 8'h4D, 8'h42},  // RMB
        {8'h52, 8'h4D, 8'h43},  // RMC
        {8'h56, 8'h48, 8'h57},  // VHW
        {8'h48, 8'h44, 8'h4D},  // HDM
        {8'h58, 8'h44, 8'h52},  // XDR
        {8'h52, 8'h4F, 8'h54},  // ROT
        {8'h52, 8'h53, 8'h41},  // RSA
        {8'h41, 8'h50, 8'h42}   // APB
    };

    // special characters
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_BANG   = 8'h21;

    // configuration register indexes and reset values
    localparam logic       REG_MIN_LENGTH   = 1'b0;
    localparam logic       REG_MAX_LENGTH   = 1'b1;
    localparam logic [7:0] MIN_LENGTH_RESET = 8'd10;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd180;
    localparam int         PADDR_WIDTH      = 3;
    localparam int         PDATA_WIDTH      = 32;

    // digit value of a hex character, HEX_NONE for anything else
    localparam logic [4:0] HEX_NONE = 5'd16;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_NONE;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = {1'b0, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    // type code from start character and characters four to six
    function automatic logic [3:0] classify(input logic [7:0] start,
                                            input logic [23:0] chars);
        logic [3:0] t;
        t = TYPE_UNKNOWN;
        if (start == CHAR_BANG)
        begin
            t = TYPE_AIS;
        end
        else
        begin
            // last match from the top leaves the first entry winning
            for (int k = NUM_TYPES - 1; k >= 0; k--)
            begin
                if (chars == TYPE_TABLE[k])
                begin
                    t = 4'(k + 1);
                end
            end
        end
        return t;
    endfunction

endpackage

FILE: rtl/nsv_core.sv
// nsv_core: per-sentence state of the nmea validator and the result logic
// holds the running xor, checksum digit gathering, byte count and type characters
// depends on nsv_pkg
module nsv_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  nsv_pkg::nsv_in_t item,
    input  logic [7:0]       min_length,
    input  logic [7:0]       max_length,
    output nsv_pkg::nsv_out_t result
);

    logic [7:0] byte_count_reg,   byte_count_next;
    logic [7:0] running_xor_reg,  running_xor_next;
    logic [7:0] xor_at_star_reg,  xor_at_star_next;
    logic       star_seen_reg,    star_seen_next;
    logic [7:0] hex_accum_reg,    hex_accum_next;
    logic       hex_overflow_reg, hex_overflow_next;
    logic       hex_stopped_reg,  hex_stopped_next;
    logic [7:0] start_char_reg,   start_char_next;
    logic [7:0] type_chars_reg  [3];
    logic [7:0] type_chars_next [3];
    logic [4:0] digit;
    logic [2:0] status;

    // state update for one sentence byte
    always_comb
    begin
        byte_count_next   = byte_count_reg;
        running_xor_next  = running_xor_reg;
        xor_at_star_next  = xor_at_star_reg;
        star_seen_next    = star_seen_reg;
        hex_accum_next    = hex_accum_reg;
        hex_overflow_next = hex_overflow_reg;
        hex_stopped_next  = hex_stopped_reg;
        start_char_next   = start_char_reg;
        type_chars_next   = type_chars_reg;
        digit             = nsv_pkg::hex_value(item.byte_value);

        if (byte_count_reg == 8'd0)
        begin
            start_char_next = item.byte_value;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (byte_count_reg == 8'(i + 3))
                begin
                    type_chars_next[i] = item.byte_value;
                end
            end
            if (item.byte_value == nsv_pkg::CHAR_STAR)
            begin
                // each star restarts the checksum field
                xor_at_star_next  = running_xor_reg;
                star_seen_next    = 1'b1;
                hex_accum_next    = 8'd0;
                hex_overflow_next = 1'b0;
                hex_stopped_next  = 1'b0;
            end
            else if (star_seen_reg && !hex_stopped_reg)
            begin
                if (digit == nsv_pkg::HEX_NONE)
                begin
                    hex_stopped_next = 1'b1;
                end
                else if (hex_overflow_reg || hex_accum_reg > 8'd15)
                begin
                    hex_overflow_next = 1'b1;
                    hex_accum_next    = 8'd255;
                end
                else
                begin
                    hex_accum_next = {hex_accum_reg[3:0], digit[3:0]};
                end
            end
            running_xor_next = running_xor_reg ^ item.byte_value;
        end

        // count saturates at 255
        if (byte_count_reg != 8'd255)
        begin
            byte_count_next = byte_count_reg + 8'd1;
        end
    end

    // checks in priority order
    always_comb
    begin
        if (byte_count_next < min_length || byte_count_next > max_length)
        begin
            status = nsv_pkg::STATUS_BAD_LENGTH;
        end
        else if (start_char_next != nsv_pkg::CHAR_DOLLAR &&
                 start_char_next != nsv_pkg::CHAR_BANG)
        begin
            status = nsv_pkg::STATUS_BAD_START;
        end
        else if (!star_seen_next)
        begin
            status = nsv_pkg::STATUS_NO_STAR;
        end
        else if (hex_overflow_next || hex_accum_next != xor_at_star_next)
        begin
            status = nsv_pkg::STATUS_MISMATCH;
        end
        else
        begin
            status = nsv_pkg::STATUS_OK;
        end
    end

    // result fields
    always_comb
    begin
        result.status          = status;
        result.sentence_type   = (status == nsv_pkg::STATUS_OK)
            ? nsv_pkg::classify(start_char_next,
                                {type_chars_next[0], type_chars_next[1],
                                 type_chars_next[2]})
            : nsv_pkg::TYPE_UNKNOWN;
        result.computed_sum    = star_seen_next ? xor_at_star_next : 8'd0;
        result.received_sum    = star_seen_next ? hex_accum_next : 8'd0;
        result.sentence_length = byte_count_next;
    end

    // sentence state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= 8'd0;
            running_xor_reg  <= 8'd0;
            xor_at_star_reg  <= 8'd0;
            star_seen_reg    <= 1'b0;
            hex_accum_reg    <= 8'd0;
            hex_overflow_reg <= 1'b0;
            hex_stopped_reg  <= 1'b0;
            start_char_reg   <= 8'd0;
            for (int i = 0; i < 3; i++)
            begin
                type_chars_reg[i] <= 8'd0;
            end
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                byte_count_reg   <= 8'd0;
                running_xor_reg  <= 8'd0;
                xor_at_star_reg  <= 8'd0;
                star_seen_reg    <= 1'b0;
                hex_accum_reg    <= 8'd0;
                hex_overflow_reg <= 1'b0;
                hex_stopped_reg  <= 1'b0;
                start_char_reg   <= 8'd0;
                for (int i = 0; i < 3; i++)
                begin
                    type_chars_reg[i] <= 8'd0;
                end
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                running_xor_reg  <= running_xor_next;
                xor_at_star_reg  <= xor_at_star_next;
                star_seen_reg    <= star_seen_next;
                hex_accum_reg    <= hex_accum_next;
                hex_overflow_reg <= hex_overflow_next;
                hex_stopped_reg  <= hex_stopped_next;
                start_char_reg   <= start_char_next;
                type_chars_reg   <= type_chars_next;
            end
        end
    end

endmodule

FILE: rtl/nmea_sentence_validator.sv
// nmea_sentence_validator: top level with input register, result register and apb registers
// checks one nmea 0183 sentence per sequence of byte transactions
// depends on nsv_pkg and nsv_core
//
// The block takes one sentence byte per cycle while no last byte is held back,
// and returns one result transaction on the byte marked last_byte: status,
// sentence type, computed and received checksum, and length. A byte goes into
// an input register, the sentence state in nsv_core is updated from it when it
// moves on, and the result of a last byte lands in an output register as that
// byte moves on; the result waits there until it is taken.
// Bytes that end no sentence keep flowing while a result waits to be taken;
// only a last byte waits for the result register to be free.
// min_length and max_length sit at byte addresses 0 and 4 of the apb port; the
// user must write them only between sentences, the block does not enforce it.
module nmea_sentence_validator (
    input  logic                             clk,
    input  logic                             rst_n,
    // sentence bytes
    input  logic                             item_valid,
    output logic                             item_ready,
    input  nsv_pkg::nsv_in_t                 item,
    // results
    output logic                             result_valid,
    input  logic                             result_ready,
    output nsv_pkg::nsv_out_t                result,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nsv_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [nsv_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic [nsv_pkg::PDATA_WIDTH-1:0]  prdata,
    output logic                             pready
);

    nsv_pkg::nsv_in_t  item_reg;
    logic              item_valid_reg;
    nsv_pkg::nsv_out_t result_reg;
    nsv_pkg::nsv_out_t core_result;
    logic              result_valid_reg;
    logic [7:0]        min_length_reg;
    logic [7:0]        max_length_reg;
    logic              result_free;
    logic              step;
    logic              reg_write;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= nsv_pkg::MIN_LENGTH_RESET;
            max_length_reg <= nsv_pkg::MAX_LENGTH_RESET;
        end
        else if (reg_write)
        begin
            if (paddr[2] == nsv_pkg::REG_MIN_LENGTH)
            begin
                min_length_reg <= pwdata[7:0];
            end
            else
            begin
                max_length_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == nsv_pkg::REG_MIN_LENGTH)
        ? {{(nsv_pkg::PDATA_WIDTH - 8){1'b0}}, min_length_reg}
        : {{(nsv_pkg::PDATA_WIDTH - 8){1'b0}}, max_length_reg};

    // a buffered byte moves on unless it ends a sentence and the result slot is full
    assign result_free = !result_valid_reg || result_ready;
    assign step        = item_valid_reg && (!item_reg.last_byte || result_free);
    assign item_ready  = !item_valid_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    nsv_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (item_reg),
        .min_length (min_length_reg),
        .max_length (max_length_reg),
        .result     (core_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (step && item_reg.last_byte)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && item_reg.last_byte)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/nsv_checker.sv
// nsv_checker: port-level assertions for the nmea sentence validator
// bound to nmea_sentence_validator; depends on nsv_pkg
module nsv_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  nsv_pkg::nsv_out_t                result
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // a failed sentence carries no type
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != nsv_pkg::STATUS_OK
        |-> result.sentence_type == nsv_pkg::TYPE_UNKNOWN)
        else $error("type set on failed sentence");

    // without a star both sums read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == nsv_pkg::STATUS_NO_STAR
        |-> result.computed_sum == 8'd0 && result.received_sum == 8'd0)
        else $error("sums set without star");

    // a passing sentence has matching sums and a nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == nsv_pkg::STATUS_OK
        |-> result.computed_sum == result.received_sum && result.sentence_length != 8'd0)
        else $error("ok status with differing sums");

    // no result appears in the cycle after reset, with no byte taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid)
        else $error("result out of reset");

endmodule

bind nmea_sentence_validator nsv_checker u_nsv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
